@@ rtl/hbd_pkg.sv @@
// Shared types and constants for the HTTP body deframer.
// Parse phases, error codes, register indexes and the structs between modules.
// No dependencies.
package hbd_pkg;

  localparam int unsigned MaxSizeDigitsDefault = 8;

  localparam logic [7:0] ByteCr = 8'd13;
  localparam logic [7:0] ByteLf = 8'd10;

  localparam logic [31:0] MaxBodySizeReset   = 32'd1048576;
  localparam logic [31:0] ContentLengthReset = 32'd0;

  typedef enum logic [2:0] {
    PH_SIZE    = 3'd0,
    PH_SIZE_LF = 3'd1,
    PH_DATA    = 3'd2,
    PH_DATA_CR = 3'd3,
    PH_DATA_LF = 3'd4,
    PH_END_CR  = 3'd5,
    PH_END_LF  = 3'd6,
    PH_DONE    = 3'd7
  } phase_e;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_MALFORMED = 2'd1,
    ERR_TOO_LARGE = 2'd2
  } err_e;

  typedef enum logic [1:0] {
    CFG_CHUNKED     = 2'd0,
    CFG_MAX_SIZE    = 2'd1,
    CFG_CONTENT_LEN = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic        chunked;
    logic [31:0] max_size;
    logic [31:0] content_len;
  } cfg_t;

  typedef struct packed {
    logic data_valid;
    logic body_done;
    err_e error_code;
  } result_t;

endpackage

@@ rtl/http_body_deframer.sv @@
// HTTP request body deframer, top level.
// Input and result registers around hbd_parser; configuration in hbd_cfg_regs.
// Depends on hbd_pkg, hbd_cfg_regs, hbd_parser.
//
// Usage:
//   Raw body bytes enter on in_byte_i with in_valid_i; a transfer happens at a
//   clock edge where in_valid_i is high and in_stall_o is low. Each byte gives
//   exactly one result on data_byte_o, data_valid_o, body_done_o, error_code_o,
//   transferred where out_valid_o is high and out_stall_i is low.
//   data_byte_o is the input byte when data_valid_o is set and zero otherwise.
//   The result is registered: a byte passes the input register and then the
//   result register. One byte per cycle is sustained while out_stall_i is
//   low; the single state update between the two registers sets that rate.
//   When the receiver stalls, the result holds, the byte in the input register
//   waits, and in_stall_o rises once both registers are full.
//   Configuration writes (chunked mode, max body size, content length) are
//   taken every cycle on cfg_valid_i; write only while no byte is in flight.
//   Reset empties both registers, clears the framing state and the sticky error,
//   and loads the register defaults; no byte is lost or invented across a stall.
module http_body_deframer #(
  parameter int unsigned MAX_SIZE_DIGITS = hbd_pkg::MaxSizeDigitsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  in_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  data_byte_o,
  output logic        data_valid_o,
  output logic        body_done_o,
  output logic [1:0]  error_code_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);
  import hbd_pkg::*;

  cfg_t    cfg;
  result_t res;

  logic       in_vld_q, in_vld_d;
  logic [7:0] in_byte_q;
  logic       out_vld_q, out_vld_d;
  logic [7:0] data_byte_q;
  logic       data_valid_q;
  logic       body_done_q;
  err_e       err_q;
  logic       out_load;
  logic       in_take;

  hbd_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  hbd_parser #(
    .MAX_SIZE_DIGITS (MAX_SIZE_DIGITS)
  ) u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (out_load),
    .byte_i    (in_byte_q),
    .cfg_i     (cfg),
    .res_o     (res)
  );

  assign out_load   = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !out_load;
  assign in_take    = in_valid_i && !in_stall_o;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_take) in_vld_d = 1'b1;
    else if (out_load) in_vld_d = 1'b0;
    out_vld_d = out_vld_q;
    if (out_load) out_vld_d = 1'b1;
    else if (!out_stall_i) out_vld_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) in_byte_q <= in_byte_i;
    if (out_load) begin
      data_byte_q  <= res.data_valid ? in_byte_q : 8'd0;
      data_valid_q <= res.data_valid;
      body_done_q  <= res.body_done;
      err_q        <= res.error_code;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign data_byte_o  = data_byte_q;
  assign data_valid_o = data_valid_q;
  assign body_done_o  = body_done_q;
  assign error_code_o = err_q;

endmodule

@@ rtl/hbd_cfg_regs.sv @@
// Configuration registers of the HTTP body deframer.
// Depends on hbd_pkg for register indexes and the cfg_t struct.
module hbd_cfg_regs (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [1:0]    cfg_index_i,
  input  logic [31:0]   cfg_data_i,
  output hbd_pkg::cfg_t cfg_o
);
  import hbd_pkg::*;

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_CHUNKED:     cfg_d.chunked     = cfg_data_i[0];
        CFG_MAX_SIZE:    cfg_d.max_size    = cfg_data_i;
        CFG_CONTENT_LEN: cfg_d.content_len = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.chunked     <= 1'b0;
      cfg_q.max_size    <= MaxBodySizeReset;
      cfg_q.content_len <= ContentLengthReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

@@ rtl/hbd_parser.sv @@
// Framing state and per-byte update of the HTTP body deframer.
// Chunked size-line parsing, length-mode counting, size limits, sticky errors.
// Depends on hbd_pkg.
module hbd_parser #(
  parameter int unsigned MAX_SIZE_DIGITS = hbd_pkg::MaxSizeDigitsDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             advance_i,
  input  logic [7:0]       byte_i,
  input  hbd_pkg::cfg_t    cfg_i,
  output hbd_pkg::result_t res_o
);
  import hbd_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_SIZE_DIGITS + 1);

  phase_e        phase_q, phase_d;
  logic [31:0]   rem_q, rem_d;
  logic [32:0]   total_q, total_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  err_e          err_q, err_d;
  logic          done_q, done_d;
  logic          pay;

  logic [4:0]    hex;
  logic [32:0]   tot_inc;
  logic [33:0]   tot_chunk;

  function automatic logic [4:0] hex_decode(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= 8'd48 && b <= 8'd57) begin
      r = {1'b1, 4'(b - 8'd48)};
    end else if (b >= 8'd97 && b <= 8'd102) begin
      r = {1'b1, 4'(b - 8'd87)};
    end else if (b >= 8'd65 && b <= 8'd70) begin
      r = {1'b1, 4'(b - 8'd55)};
    end
    return r;
  endfunction

  assign hex       = hex_decode(byte_i);
  assign tot_inc   = total_q + 33'd1;
  assign tot_chunk = {1'b0, total_q} + {2'b00, rem_q};

  always_comb begin
    phase_d = phase_q;
    rem_d   = rem_q;
    total_d = total_q;
    cnt_d   = cnt_q;
    err_d   = err_q;
    done_d  = done_q;
    pay     = 1'b0;
    if (err_q == ERR_NONE) begin
      if (cfg_i.chunked) begin
        unique case (phase_q)
          PH_SIZE: begin
            if (byte_i == ByteCr) begin
              if (cnt_q == '0) err_d = ERR_MALFORMED;
              else phase_d = PH_SIZE_LF;
            end else if (!hex[4] || cnt_q >= CntW'(MAX_SIZE_DIGITS)) begin
              err_d = ERR_MALFORMED;
            end else if (rem_q[31:28] != 4'd0) begin
              err_d = ERR_TOO_LARGE;
            end else begin
              rem_d = {rem_q[27:0], hex[3:0]};
              cnt_d = cnt_q + 1'b1;
            end
          end
          PH_SIZE_LF: begin
            if (byte_i != ByteLf) begin
              err_d = ERR_MALFORMED;
            end else if (rem_q == 32'd0) begin
              phase_d = PH_END_CR;
            end else if (tot_chunk > {2'b00, cfg_i.max_size}) begin
              err_d = ERR_TOO_LARGE;
            end else begin
              phase_d = PH_DATA;
            end
          end
          PH_DATA: begin
            rem_d   = rem_q - 32'd1;
            total_d = tot_inc;
            pay     = 1'b1;
            if (rem_q == 32'd1) phase_d = PH_DATA_CR;
          end
          PH_DATA_CR: begin
            if (byte_i != ByteCr) err_d = ERR_MALFORMED;
            else phase_d = PH_DATA_LF;
          end
          PH_DATA_LF: begin
            if (byte_i != ByteLf) begin
              err_d = ERR_MALFORMED;
            end else begin
              phase_d = PH_SIZE;
              rem_d   = 32'd0;
              cnt_d   = '0;
            end
          end
          PH_END_CR: begin
            if (byte_i != ByteCr) err_d = ERR_MALFORMED;
            else phase_d = PH_END_LF;
          end
          PH_END_LF: begin
            if (byte_i != ByteLf) begin
              err_d = ERR_MALFORMED;
            end else begin
              phase_d = PH_DONE;
              done_d  = 1'b1;
            end
          end
          PH_DONE: err_d = ERR_MALFORMED;
        endcase
      end else begin
        if (done_q) begin
          err_d = ERR_MALFORMED;
        end else begin
          if (total_q == {1'b0, cfg_i.content_len}) done_d = 1'b1;
          if (tot_inc > {1'b0, cfg_i.max_size}) begin
            err_d = ERR_TOO_LARGE;
          end else if (tot_inc > {1'b0, cfg_i.content_len}) begin
            err_d = ERR_MALFORMED;
          end else begin
            total_d = tot_inc;
            pay     = 1'b1;
            if (tot_inc == {1'b0, cfg_i.content_len}) done_d = 1'b1;
          end
        end
      end
    end
  end

  assign res_o.data_valid = pay;
  assign res_o.body_done  = done_d;
  assign res_o.error_code = err_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SIZE;
      rem_q   <= 32'd0;
      total_q <= 33'd0;
      cnt_q   <= '0;
      err_q   <= ERR_NONE;
      done_q  <= 1'b0;
    end else if (advance_i) begin
      phase_q <= phase_d;
      rem_q   <= rem_d;
      total_q <= total_d;
      cnt_q   <= cnt_d;
      err_q   <= err_d;
      done_q  <= done_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_sticky_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (err_q != ERR_NONE) |=> (err_q == $past(err_q)) && $stable(phase_q)
      && $stable(total_q) && $stable(done_q))
    else $error("state changed after a sticky error");

  a_data_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_DATA) |-> (rem_q != 32'd0))
    else $error("data phase with no bytes remaining");

  a_pay_no_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pay |-> (err_q == ERR_NONE) && (err_d == ERR_NONE))
    else $error("payload passed with an error");

  a_digit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MAX_SIZE_DIGITS))
    else $error("size digit count over limit");
`endif

endmodule

@@ tb/tb_top.sv @@
// Testbench for http_body_deframer: chunked and length-mode bodies, mode switches, one closing error.
// A scoreboard class predicts one result per byte and checks the result stream.
// Depends on hbd_pkg and the http_body_deframer RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import hbd_pkg::*;

  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned RandomBytes   = 600;

  typedef struct {
    logic [7:0] data_byte;
    logic       data_valid;
    logic       body_done;
    err_e       error_code;
  } frame_result_t;

  typedef enum int {
    END_BAD_HEX, END_EMPTY_SIZE, END_LONG_SIZE, END_CHUNK_OVER_MAX, END_NO_DATA_CR,
    END_NO_SIZE_LF, END_CHUNKED_PAST_DONE, END_LENGTH_PAST_DONE, END_LENGTH_OVER_MAX,
    END_LENGTH_OVER_LEN
  } closing_e;

  class body_checker;
    logic            chunked     = 1'b0;
    logic [31:0]     max_size    = MaxBodySizeReset;
    logic [31:0]     content_len = ContentLengthReset;
    phase_e          phase       = PH_SIZE;
    logic [31:0]     remaining   = '0;
    logic [32:0]     body_total  = '0;
    int unsigned     digits      = 0;
    err_e            sticky_err  = ERR_NONE;
    logic            done_flag   = 1'b0;
    int unsigned     errors      = 0;
    int unsigned     n_payload   = 0;
    frame_result_t   pending_results[$];

    function void set_reg(cfg_idx_e idx, logic [31:0] value);
      case (idx)
        CFG_CHUNKED:     chunked = value[0];
        CFG_MAX_SIZE:    max_size = value;
        CFG_CONTENT_LEN: content_len = value;
        default: ;
      endcase
    endfunction

    function void note_byte(logic [7:0] b);
      frame_result_t r;
      logic          is_payload;
      int            nib;
      is_payload = 1'b0;
      if (sticky_err == ERR_NONE) begin
        if (chunked) begin
          case (phase)
            PH_SIZE: begin
              if (b == ByteCr) begin
                if (digits == 0) sticky_err = ERR_MALFORMED;
                else phase = PH_SIZE_LF;
              end else begin
                if (b >= 8'h30 && b <= 8'h39) nib = int'(b) - 48;
                else if (b >= 8'h61 && b <= 8'h66) nib = int'(b) - 87;
                else if (b >= 8'h41 && b <= 8'h46) nib = int'(b) - 55;
                else nib = -1;
                if (nib < 0 || digits >= MaxSizeDigitsDefault) sticky_err = ERR_MALFORMED;
                else if (remaining[31:28] != 4'd0) sticky_err = ERR_TOO_LARGE;
                else begin
                  remaining = {remaining[27:0], nib[3:0]};
                  digits++;
                end
              end
            end
            PH_SIZE_LF: begin
              if (b != ByteLf) sticky_err = ERR_MALFORMED;
              else if (remaining == 0) phase = PH_END_CR;
              else if (body_total + remaining > {1'b0, max_size}) sticky_err = ERR_TOO_LARGE;
              else phase = PH_DATA;
            end
            PH_DATA: begin
              remaining--;
              body_total++;
              if (remaining == 0) phase = PH_DATA_CR;
              is_payload = 1'b1;
            end
            PH_DATA_CR: begin
              if (b != ByteCr) sticky_err = ERR_MALFORMED;
              else phase = PH_DATA_LF;
            end
            PH_DATA_LF: begin
              if (b != ByteLf) sticky_err = ERR_MALFORMED;
              else begin
                phase = PH_SIZE;
                remaining = '0;
                digits = 0;
              end
            end
            PH_END_CR: begin
              if (b != ByteCr) sticky_err = ERR_MALFORMED;
              else phase = PH_END_LF;
            end
            PH_END_LF: begin
              if (b != ByteLf) sticky_err = ERR_MALFORMED;
              else begin
                phase = PH_DONE;
                done_flag = 1'b1;
              end
            end
            default: sticky_err = ERR_MALFORMED;
          endcase
        end else if (done_flag) begin
          sticky_err = ERR_MALFORMED;
        end else begin
          if (body_total + 33'd1 > {1'b0, max_size}) sticky_err = ERR_TOO_LARGE;
          else if (body_total + 33'd1 > {1'b0, content_len}) sticky_err = ERR_MALFORMED;
          if (body_total == {1'b0, content_len}) done_flag = 1'b1;
          if (sticky_err == ERR_NONE) begin
            body_total++;
            if (body_total == {1'b0, content_len}) done_flag = 1'b1;
            is_payload = 1'b1;
          end
        end
      end
      if (is_payload) n_payload++;
      r.data_byte  = is_payload ? b : 8'd0;
      r.data_valid = is_payload;
      r.body_done  = done_flag;
      r.error_code = sticky_err;
      pending_results.push_back(r);
    endfunction

    function void check_result(logic [7:0] d, logic v, logic dn, logic [1:0] e);
      frame_result_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result: data %h valid %b done %b error %0d",
                 $time, d, v, dn, e);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      if (d !== want.data_byte) begin
        $display("%0t: data_byte expected %h, actual %h", $time, want.data_byte, d);
        errors++;
      end
      if (v !== want.data_valid) begin
        $display("%0t: data_valid expected %b, actual %b", $time, want.data_valid, v);
        errors++;
      end
      if (dn !== want.body_done) begin
        $display("%0t: body_done expected %b, actual %b", $time, want.body_done, dn);
        errors++;
      end
      if (e !== want.error_code) begin
        $display("%0t: error_code expected %0d, actual %0d", $time, want.error_code, e);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic [7:0]  in_byte_i   = 8'd0;
  logic        out_stall_i = 1'b1;
  logic        cfg_valid_i = 1'b0;
  logic [1:0]  cfg_index_i = CFG_CHUNKED;
  logic [31:0] cfg_data_i  = '0;
  logic        in_stall_o;
  logic        out_valid_o;
  logic [7:0]  data_byte_o;
  logic        data_valid_o;
  logic        body_done_o;
  logic [1:0]  error_code_o;
  logic        cfg_ready_o;

  body_checker chk = new();
  logic [7:0]  stream_q[$];
  int unsigned n_sent = 0;
  int unsigned n_cfg = 0;
  int unsigned stuck_cycles = 0;
  bit          no_idle = 1'b0;
  closing_e    closing;

  http_body_deframer i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_byte_i    (in_byte_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .data_byte_o  (data_byte_o),
    .data_valid_o (data_valid_o),
    .body_done_o  (body_done_o),
    .error_code_o (error_code_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      chk.check_result(data_byte_o, data_valid_o, body_done_o, error_code_o);
    end
    out_stall_i <= !no_idle && ($urandom_range(99) < 35);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= WatchdogLimit) begin
      $display("%0t: no transfer for %0d cycles", $time, WatchdogLimit);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  task automatic push_byte(logic [7:0] b);
    no_idle = (n_sent >= 250 && n_sent < 400);
    while (!no_idle && $urandom_range(99) < 35) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_byte_i  <= b;
    do @(posedge clk_i); while (in_stall_o);
    chk.note_byte(b);
    n_sent++;
  endtask

  task automatic send_stream(int unsigned n);
    repeat (n) push_byte(stream_q.pop_front());
  endtask

  task automatic send_random(int unsigned n);
    repeat (n) push_byte(8'($urandom));
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (chk.pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [31:0] value);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    chk.set_reg(idx, value);
    n_cfg++;
  endtask

  function automatic void push_hex(logic [31:0] v, int ndig);
    logic [3:0] nib;
    for (int i = ndig - 1; i >= 0; i--) begin
      nib = v[4*i +: 4];
      if (nib < 4'd10) stream_q.push_back(8'h30 + nib);
      else if ($urandom_range(1) == 1) stream_q.push_back(8'h41 + nib - 8'd10);
      else stream_q.push_back(8'h61 + nib - 8'd10);
    end
  endfunction

  function automatic void append_chunk(int unsigned len);
    int ndig;
    ndig = 1;
    while (ndig < 8 && (len >> (4 * ndig)) != 0) ndig++;
    if ($urandom_range(3) == 0) ndig = $urandom_range(8, ndig);
    push_hex(len, ndig);
    stream_q.push_back(ByteCr);
    stream_q.push_back(ByteLf);
    repeat (len) stream_q.push_back(8'($urandom));
    stream_q.push_back(ByteCr);
    stream_q.push_back(ByteLf);
  endfunction

  task automatic chunked_burst();
    int unsigned n;
    int unsigned sel;
    if (!chk.chunked) write_reg(CFG_CHUNKED, 32'd1);
    if ({1'b0, chk.max_size} < chk.body_total + 33'd2000) begin
      write_reg(CFG_MAX_SIZE, ($urandom_range(1) == 1) ? '1 : 32'(chk.body_total + 33'd20000));
    end
    n = $urandom_range(60, 5);
    while (stream_q.size() < n) begin
      sel = $urandom_range(99);
      if (sel < 70) append_chunk($urandom_range(15, 1));
      else if (sel < 95) append_chunk($urandom_range(64, 16));
      else append_chunk($urandom_range(300, 65));
    end
    send_stream(n);
  endtask

  task automatic length_burst();
    int unsigned k;
    k = $urandom_range(30, 1);
    if (chk.chunked) write_reg(CFG_CHUNKED, 32'd0);
    case ($urandom_range(3))
      0:       write_reg(CFG_CONTENT_LEN, 32'(chk.body_total + k));
      1:       write_reg(CFG_CONTENT_LEN, '1);
      default: write_reg(CFG_CONTENT_LEN, 32'(chk.body_total + k + $urandom_range(500, 1)));
    endcase
    if ($urandom_range(3) == 0) write_reg(CFG_MAX_SIZE, 32'(chk.body_total + k));
    else if ({1'b0, chk.max_size} < chk.body_total + k) write_reg(CFG_MAX_SIZE, '1);
    send_random(k);
  endtask

  initial begin
    logic [7:0]  b;
    int unsigned m;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    write_reg(CFG_CHUNKED, 32'd1);
    write_reg(CFG_MAX_SIZE, '1);
    write_reg(CFG_CONTENT_LEN, '1);
    push_hex(32'd1, 8);
    stream_q.push_back(ByteCr);
    stream_q.push_back(ByteLf);
    stream_q.push_back(8'hFF);
    stream_q.push_back(ByteCr);
    stream_q.push_back(ByteLf);
    push_hex(32'd2, 1);
    stream_q.push_back(ByteCr);
    stream_q.push_back(ByteLf);
    stream_q.push_back(8'h00);
    stream_q.push_back(ByteCr);
    stream_q.push_back(ByteCr);
    stream_q.push_back(ByteLf);
    send_stream(stream_q.size());

    while (n_sent < RandomBytes) begin
      if (!chk.done_flag && $urandom_range(99) < 25) length_burst();
      else chunked_burst();
    end

    if (!chk.chunked) write_reg(CFG_CHUNKED, 32'd1);
    if ({1'b0, chk.max_size} < chk.body_total + 33'd2000) write_reg(CFG_MAX_SIZE, '1);
    send_stream(stream_q.size());

    closing = closing_e'($urandom_range(9));
    m = $urandom_range(20, 1);
    case (closing)
      END_BAD_HEX: begin
        push_hex($urandom, $urandom_range(3));
        do b = 8'($urandom);
        while ((b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h46) ||
               (b >= 8'h61 && b <= 8'h66) || b == ByteCr);
        stream_q.push_back(b);
      end
      END_EMPTY_SIZE: stream_q.push_back(ByteCr);
      END_LONG_SIZE: begin
        stream_q.push_back(8'h30);
        push_hex($urandom, 8);
      end
      END_CHUNK_OVER_MAX: begin
        write_reg(CFG_MAX_SIZE, 32'(chk.body_total + m));
        append_chunk(m);
        send_stream(stream_q.size());
        m = $urandom_range(20, 1);
        write_reg(CFG_MAX_SIZE, 32'(chk.body_total + m - 1));
        push_hex(m, 2);
        stream_q.push_back(ByteCr);
        stream_q.push_back(ByteLf);
      end
      END_NO_DATA_CR: begin
        append_chunk(m);
        void'(stream_q.pop_back());
        void'(stream_q.pop_back());
        do b = 8'($urandom); while (b == ByteCr);
        stream_q.push_back(b);
      end
      END_NO_SIZE_LF: begin
        push_hex(m, 2);
        stream_q.push_back(ByteCr);
        do b = 8'($urandom); while (b == ByteLf);
        stream_q.push_back(b);
      end
      END_CHUNKED_PAST_DONE: begin
        push_hex(32'd0, $urandom_range(8, 1));
        stream_q.push_back(ByteCr);
        stream_q.push_back(ByteLf);
        if ($urandom_range(3) == 0) begin
          do b = 8'($urandom); while (b == ByteCr);
          stream_q.push_back(b);
        end else begin
          stream_q.push_back(ByteCr);
          stream_q.push_back(ByteLf);
          stream_q.push_back(8'($urandom));
        end
      end
      END_LENGTH_PAST_DONE: begin
        write_reg(CFG_CHUNKED, 32'd0);
        write_reg(CFG_CONTENT_LEN, 32'(chk.body_total + m));
        send_random(m + 1);
      end
      END_LENGTH_OVER_MAX: begin
        write_reg(CFG_CHUNKED, 32'd0);
        write_reg(CFG_CONTENT_LEN, '1);
        write_reg(CFG_MAX_SIZE, ($urandom_range(1) == 1) ? 32'd0 : 32'(chk.body_total + m));
        send_random(m + 1);
      end
      default: begin
        write_reg(CFG_CHUNKED, 32'd0);
        write_reg(CFG_CONTENT_LEN, 32'd0);
        send_random(1);
      end
    endcase
    send_stream(stream_q.size());
    send_random(20);

    drain();
    repeat (10) @(posedge clk_i);
    $display("Sent %0d body bytes with %0d register writes; %0d came out as payload.",
             n_sent, n_cfg, chk.n_payload);
    $display("Closing case %s, final error code %0d, body_done %b.",
             closing.name(), chk.sticky_err, chk.done_flag);
    if (chk.errors == 0 && chk.pending_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
